/* rtl/core/tks_pkg.sv */
// Shared constants and types for the top-K norm select block.
`default_nettype none
package tks_pkg;

  localparam int DEF_MAX_ITEMS  = 1024;
  localparam int DEF_MAX_SELECT = 64;

  localparam int SCORE_W = 16;
  localparam int NORM_W  = 32;
  localparam int INDEX_W = 10;
  localparam int SEL_W   = 7;

  localparam logic [SEL_W-1:0] SELECT_RESET = 7'd1;

  typedef struct packed {
    logic go;
    logic wr;
    logic last;
  } load_req_t;

  typedef struct packed {
    logic wr;
    logic last;
  } load_status_t;

endpackage
`default_nettype wire

/* rtl/core/tks_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tks_ram #(
  parameter int WIDTH = tks_pkg::NORM_W,
  parameter int DEPTH = tks_pkg::DEF_MAX_ITEMS
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/tks_load.sv */
// Load stage: squares both scores and forms the norm word for the store.
`default_nettype none
module tks_load #(
  parameter int AW = $clog2(tks_pkg::DEF_MAX_ITEMS)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire tks_pkg::load_req_t                req,
  input  wire logic [AW-1:0]                     addr,
  input  wire logic signed [tks_pkg::SCORE_W-1:0] soft_score,
  input  wire logic signed [tks_pkg::SCORE_W-1:0] hard_score,
  output tks_pkg::load_status_t                  status,
  output logic      [AW-1:0]                     wr_addr,
  output logic      [tks_pkg::NORM_W-1:0]        wr_data
);

  logic signed [2*tks_pkg::SCORE_W-1:0] soft_prod;
  logic signed [2*tks_pkg::SCORE_W-1:0] hard_prod;
  logic        [tks_pkg::NORM_W-1:0]    sq_soft;
  logic        [tks_pkg::NORM_W-1:0]    sq_hard;
  logic                                 wr_q;
  logic                                 last_q;

  assign soft_prod = soft_score * soft_score;
  assign hard_prod = hard_score * hard_score;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_q   <= 1'b0;
      last_q <= 1'b0;
    end else begin
      wr_q   <= req.go && req.wr;
      last_q <= req.go && req.last;
    end
    if (req.go) begin
      sq_soft <= tks_pkg::NORM_W'($unsigned(soft_prod));
      sq_hard <= tks_pkg::NORM_W'($unsigned(hard_prod));
      wr_addr <= addr;
    end
  end

  assign wr_data     = sq_soft + sq_hard;
  assign status.wr   = wr_q;
  assign status.last = last_q;

endmodule
`default_nettype wire

/* rtl/core/tks_select.sv */
// Sequencer: item counting, selection passes over the norm store, result register.
`default_nettype none
module tks_select #(
  parameter int MAX_ITEMS  = tks_pkg::DEF_MAX_ITEMS,
  parameter int MAX_SELECT = tks_pkg::DEF_MAX_SELECT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                last_item,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tks_pkg::SEL_W-1:0]           select_count,
  output tks_pkg::load_req_t                       ld_req,
  output logic      [$clog2(MAX_ITEMS)-1:0]        ld_addr,
  input  wire tks_pkg::load_status_t               ld_status,
  input  wire logic [$clog2(MAX_ITEMS)-1:0]        ld_waddr,
  input  wire logic [tks_pkg::NORM_W-1:0]          ld_wdata,
  output logic                                     mem_we,
  output logic      [$clog2(MAX_ITEMS)-1:0]        mem_waddr,
  output logic      [tks_pkg::NORM_W-1:0]          mem_wdata,
  output logic                                     mem_re,
  output logic      [$clog2(MAX_ITEMS)-1:0]        mem_raddr,
  input  wire logic [tks_pkg::NORM_W-1:0]          mem_rdata,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [tks_pkg::INDEX_W-1:0]         chosen_index,
  output logic                                     last_choice
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = tks_pkg::SEL_W;

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_FLUSH = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]                   state;
  logic [CW-1:0]                item_count;
  logic [CW-1:0]                issue_cnt;
  logic                         rd_valid;
  logic [AW-1:0]                rd_idx;
  logic [AW-1:0]                best;
  logic [tks_pkg::NORM_W-1:0]   best_val;
  logic [SW-1:0]                pass_cnt;
  logic [SW-1:0]                k_run;
  logic [SW-1:0]                k_limit;
  logic [SW-1:0]                k_sat;
  logic                         accept;
  logic                         out_free;
  logic                         emit;
  logic                         final_pass;
  logic [AW+tks_pkg::INDEX_W-1:0] best_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_LOAD);
  assign accept    = in_valid && (state == S_LOAD);

  assign ld_req.go   = accept;
  assign ld_req.wr   = (item_count < CW'(MAX_ITEMS));
  assign ld_req.last = last_item;
  assign ld_addr     = item_count[AW-1:0];

  assign k_sat = (k_limit > SW'(MAX_SELECT)) ? SW'(MAX_SELECT) : k_limit;

  assign out_free   = !out_valid || !out_stall;
  assign emit       = (state == S_EMIT) && out_free;
  assign final_pass = ((pass_cnt + SW'(1)) == k_run);
  assign best_ext   = {{tks_pkg::INDEX_W{1'b0}}, best};

  assign mem_re    = (state == S_SCAN) && (issue_cnt < item_count);
  assign mem_raddr = issue_cnt[AW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ld_waddr;
    mem_wdata = ld_wdata;
    if (ld_status.wr) begin
      mem_we = 1'b1;
    end else if (emit) begin
      mem_we    = 1'b1;
      mem_waddr = best;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      item_count <= '0;
      issue_cnt  <= '0;
      rd_valid   <= 1'b0;
      pass_cnt   <= '0;
      k_run      <= '0;
      k_limit    <= tks_pkg::SELECT_RESET;
      out_valid  <= 1'b0;
    end else begin
      rd_valid <= mem_re;
      if (cfg_valid && cfg_ready) begin
        k_limit <= select_count;
      end
      if (out_valid && !out_stall && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (accept && ld_req.wr) begin
            item_count <= item_count + CW'(1);
          end
          if (accept && last_item) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          pass_cnt  <= '0;
          issue_cnt <= '0;
          k_run     <= k_sat;
          if (k_sat == '0) begin
            item_count <= '0;
            state      <= S_LOAD;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (mem_re) begin
            issue_cnt <= issue_cnt + CW'(1);
          end else if (!rd_valid) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (final_pass) begin
              item_count <= '0;
              state      <= S_LOAD;
            end else begin
              pass_cnt  <= pass_cnt + SW'(1);
              issue_cnt <= '0;
              state     <= S_SCAN;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= issue_cnt[AW-1:0];
    if ((state == S_FLUSH) || emit) begin
      best     <= '0;
      best_val <= '0;
    end else if (rd_valid && (mem_rdata > best_val)) begin
      best     <= rd_idx;
      best_val <= mem_rdata;
    end
    if (emit) begin
      chosen_index <= best_ext[tks_pkg::INDEX_W-1:0];
      last_choice  <= final_pass;
    end
  end

  a_load_write_phase: assert property (@(posedge clk) disable iff (rst)
    ld_status.wr |-> ((state == S_LOAD) || (state == S_FLUSH)))
    else $error("store write from load stage outside load phase");

  a_last_starts_flush: assert property (@(posedge clk) disable iff (rst)
    ld_status.last |-> (state == S_FLUSH))
    else $error("last word did not start selection");

  a_read_from_scan: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> ($past(state) == S_SCAN))
    else $error("read data returned without a scan issue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= CW'(MAX_ITEMS))
    else $error("item count beyond store depth");

  a_empty_pick: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && (best_val == '0)) |-> (best == '0))
    else $error("no eligible item but nonzero index");

  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) || (state == S_EMIT)) |-> (pass_cnt < k_run))
    else $error("selection pass count overrun");

endmodule
`default_nettype wire

/* rtl/core/top_k_norm_select_top.sv */
// Top level of the top-K norm select block.
//
// Items load at one per cycle while in_stall is low: each item's soft*soft +
// hard*hard is written into a single norm RAM (one write port, one registered
// read port) through a one-stage square pipeline. The item with last_item high
// starts selection and in_stall stays high until the set is done. Each of the
// K passes (K is select_count, saturated at MAX_SELECT) streams all N stored
// norms through the RAM read port, one per cycle; a result held by out_stall
// delays the set. A picked entry is overwritten with zero in the RAM, so no
// mark store and no clearing pass are needed; the block is ready right after
// reset. Items past MAX_ITEMS are dropped, and a pass that finds no nonzero
// norm returns index 0.
`default_nettype none
module top_k_norm_select_top #(
  parameter int MAX_ITEMS  = tks_pkg::DEF_MAX_ITEMS,
  parameter int MAX_SELECT = tks_pkg::DEF_MAX_SELECT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [tks_pkg::SCORE_W-1:0] soft_score,
  input  wire logic signed [tks_pkg::SCORE_W-1:0] hard_score,
  input  wire logic                               last_item,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tks_pkg::SEL_W-1:0]          select_count,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [tks_pkg::INDEX_W-1:0]        chosen_index,
  output logic                                    last_choice
);

  localparam int AW = $clog2(MAX_ITEMS);

  tks_pkg::load_req_t         ld_req;
  tks_pkg::load_status_t      ld_status;
  logic [AW-1:0]              ld_addr;
  logic [AW-1:0]              ld_waddr;
  logic [tks_pkg::NORM_W-1:0] ld_wdata;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [tks_pkg::NORM_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [tks_pkg::NORM_W-1:0] mem_rdata;

  tks_ram #(
    .WIDTH (tks_pkg::NORM_W),
    .DEPTH (MAX_ITEMS)
  ) u_norm_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tks_load #(
    .AW (AW)
  ) u_load (
    .clk        (clk),
    .rst        (rst),
    .req        (ld_req),
    .addr       (ld_addr),
    .soft_score (soft_score),
    .hard_score (hard_score),
    .status     (ld_status),
    .wr_addr    (ld_waddr),
    .wr_data    (ld_wdata)
  );

  tks_select #(
    .MAX_ITEMS  (MAX_ITEMS),
    .MAX_SELECT (MAX_SELECT)
  ) u_select (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .last_item    (last_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .select_count (select_count),
    .ld_req       (ld_req),
    .ld_addr      (ld_addr),
    .ld_status    (ld_status),
    .ld_waddr     (ld_waddr),
    .ld_wdata     (ld_wdata),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chosen_index (chosen_index),
    .last_choice  (last_choice)
  );

endmodule
`default_nettype wire
